/* rtl/bsks_pkg.sv */
// shared constants, codes and control types of the bounded stack with kind sum
package bsks_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int ACC_RAW_W = 33 + $clog2(STACK_DEPTH);
  localparam int ACC_W = (ACC_RAW_W > 35) ? ACC_RAW_W : 35;

  localparam int ACTION_W = 3;
  localparam int NAME_W = 64;
  localparam int KIND_W = 8;
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W = 35;
  localparam int ENTRY_COUNT_W = 4;

  localparam int IN_BITS = ACTION_W + NAME_W + KIND_W + VALUE_W + KIND_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + NAME_W + KIND_W + VALUE_W + TOTAL_W + ENTRY_COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SUM = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
  } rec_t;

  typedef struct packed {
    logic                latch;
    logic                res_clear;
    logic [STATUS_W-1:0] status;
    logic                push;
    logic                rd_top;
    logic                rd_first;
    logic                rd_next;
    logic                take_rec;
    logic                pop_dec;
    logic                clr;
    logic                acc_add;
    logic                out_load;
  } bsks_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                empty;
    logic                full;
    logic                sum_last;
    logic                out_free;
  } bsks_sts_t;

endpackage

/* rtl/bsks_ctrl.sv */
// controller state machine sequencing each action of the stack
module bsks_ctrl import bsks_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bsks_sts_t sts,
  output bsks_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_SUM = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.status = ST_OK;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_clear = 1'b1;
        state_next = S_DONE;
        case (sts.act)
          ACT_PUSH: begin
            if (sts.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (sts.empty) begin
              cmd.status = ST_EMPTY;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_FETCH;
            end
          end
          ACT_CLEAR: begin
            cmd.clr = 1'b1;
          end
          ACT_SUM: begin
            if (sts.empty) begin
              cmd.status = ST_EMPTY;
            end else begin
              cmd.rd_first = 1'b1;
              state_next = S_SUM;
            end
          end
          default: begin
          end
        endcase
      end
      S_FETCH: begin
        cmd.take_rec = 1'b1;
        cmd.pop_dec = (sts.act == ACT_POP);
        state_next = S_DONE;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        if (sts.sum_last) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bsks_dp.sv */
// datapath: record memory, fill count, sum accumulator and output register
module bsks_dp import bsks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  bsks_cmd_t             cmd,
  output bsks_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  rec_t mem [STACK_DEPTH];
  rec_t rd_data;

  logic [ACTION_W-1:0] act;
  rec_t                in_rec;
  logic [KIND_W-1:0]   query_kind;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] top_cnt;
  logic [PTR_W-1:0] top_addr;
  logic [PTR_W-1:0] sidx;
  logic [PTR_W-1:0] sidx_next;
  logic [PTR_W-1:0] rd_addr;

  logic [STATUS_W-1:0]      res_status;
  rec_t                     res_rec;
  logic signed [ACC_W-1:0]  acc;
  logic signed [VALUE_W-1:0] rd_value;
  logic signed [TOTAL_W-1:0] total_sat;

  assign top_cnt = count - 1'b1;
  assign top_addr = top_cnt[PTR_W-1:0];
  assign sidx_next = sidx + 1'b1;
  assign rd_value = $signed(rd_data.value);

  always_comb begin
    rd_addr = sidx_next;
    if (cmd.rd_top) begin
      rd_addr = top_addr;
    end else if (cmd.rd_first) begin
      rd_addr = '0;
    end
  end

  always_comb begin
    if (acc > ACC_W'(TOTAL_MAX)) begin
      total_sat = TOTAL_MAX;
    end else if (acc < ACC_W'(TOTAL_MIN)) begin
      total_sat = TOTAL_MIN;
    end else begin
      total_sat = acc[TOTAL_W-1:0];
    end
  end

  assign sts.act = act;
  assign sts.empty = (count == '0);
  assign sts.full = (count == CNT_W'(STACK_DEPTH));
  assign sts.sum_last = (CNT_W'(sidx) == top_cnt);
  assign sts.out_free = !out_valid || out_ready;

  // record memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[PTR_W-1:0]] <= in_rec;
    end
    if (cmd.rd_top || cmd.rd_first || cmd.rd_next) begin
      rd_data <= mem[rd_addr];
    end
  end

  // latched input item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act <= in_data[ACTION_W-1:0];
      in_rec.name <= in_data[ACTION_W +: NAME_W];
      in_rec.kind <= in_data[ACTION_W+NAME_W +: KIND_W];
      in_rec.value <= in_data[ACTION_W+NAME_W+KIND_W +: VALUE_W];
      query_kind <= in_data[ACTION_W+NAME_W+KIND_W+VALUE_W +: KIND_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clr) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end else if (cmd.pop_dec) begin
      count <= top_cnt;
    end
  end

  // result fields and sum walk
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_status <= cmd.status;
      res_rec <= '0;
      acc <= '0;
      sidx <= '0;
    end else begin
      if (cmd.take_rec) begin
        res_rec <= rd_data;
      end
      if (cmd.acc_add && (rd_data.kind == query_kind)) begin
        acc <= acc + ACC_W'(rd_value);
      end
      if (cmd.rd_next) begin
        sidx <= sidx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_DATA_W'({ENTRY_COUNT_W'(count), total_sat, res_rec.value,
                               res_rec.kind, res_rec.name, res_status});
    end
  end

endmodule

/* rtl/bounded_stack_with_kind_sum_unit.sv */
// top level of the bounded stack with kind sum
//
// usage: one item in on the s_ channel carries an action (push, pop, clear,
// peek top, sum by kind) and the record or query fields; exactly one item
// comes out on the m_ channel with status, the popped or peeked record, the
// saturated kind sum and the record count after the action.
// the stack holds up to eight records; a full push or an empty pop, peek or
// sum reports an error status and leaves the stack unchanged.
// push, clear and unused codes go straight from the action to the output;
// pop and peek add one registered memory read, and sum walks the n stored
// records with one adder, one record per cycle.
// one item is in work at a time; the next item is accepted as soon as the
// previous result sits in the output register, so with a ready receiver
// the spacing of items is set by the action and the count.
// reset empties the stack and drops any pending output item.
// when the receiver stalls, the output item holds; the block accepts and works
// on one more item and then waits until the output register is taken.
module bounded_stack_with_kind_sum_unit import bsks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // action, entry_name, entry_kind, entry_value, query_kind
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status, out_name, out_kind, out_value, kind_total, entry_count
  output logic [OUT_DATA_W-1:0] m_tdata
);

  bsks_cmd_t cmd;
  bsks_sts_t sts;

  bsks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsks_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
